// File: rtl/round_brush_mask_alpha_top_macros.svh
// Assertion helpers shared by rbm_cfg, rbm_fifo and rbm_back.
`ifndef ROUND_BRUSH_MASK_ALPHA_TOP_MACROS_SVH
`define ROUND_BRUSH_MASK_ALPHA_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define RBM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Antecedent at one edge implies the consequent at the next edge
`define RBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbm_pkg;

  localparam int SIZE_W     = 12;
  localparam int HARD_W     = 7;
  localparam int COORD_W    = 10;
  localparam int ALPHA_W    = 8;
  localparam int WIDTH_W    = 10;
  localparam int HALF_W     = 9;
  localparam int DIST_W     = 9;
  localparam int D2_W       = 18;
  localparam int ROOT_W     = 30;
  localparam int RATIO_W    = 18;
  localparam int Q16_W      = 17;
  localparam int T_W        = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int FIFO_DEPTH = 4;

  localparam int MAX_DIAMETER_DEF = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HARDNESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTIALIAS  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 12'd320;
  localparam logic [HARD_W-1:0] HARD_RST = 7'd100;
  localparam logic              AA_RST   = 1'b1;

  localparam logic [HARD_W-1:0] HARD_FULL = 7'd100;
  localparam logic [Q16_W-1:0]  ONE_Q16   = 17'h10000;

  // pixel after the front stage
  typedef struct packed {
    logic               in_stamp;
    logic [WIDTH_W-1:0] width;
    logic [D2_W-1:0]    d2;
  } rbm_item_t;

  // configuration and derived constants
  typedef struct packed {
    logic [SIZE_W-1:0]  brush_size;
    logic [HALF_W-1:0]  half;
    logic [WIDTH_W-1:0] width;
    logic               hard_full;
    logic [Q16_W-1:0]   hard_q16;
    logic [T_W-1:0]     band_t;
    logic               busy;
  } rbm_cfg_t;

endpackage
`default_nettype wire

// File: rtl/rbm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// pixel coordinate channel
interface rbm_pix_if;
  logic                             valid;
  logic                             ready;
  logic [rbm_pkg::COORD_W-1:0]      pixel_x;
  logic [rbm_pkg::COORD_W-1:0]      pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// alpha result channel
interface rbm_alpha_if;
  logic                             valid;
  logic                             ready;
  logic [rbm_pkg::ALPHA_W-1:0]      mask_alpha;
  logic [rbm_pkg::WIDTH_W-1:0]      stamp_width;
  modport source (output valid, output mask_alpha, output stamp_width, input ready);
  modport sink   (input valid, input mask_alpha, input stamp_width, output ready);
endinterface
`default_nettype wire

// File: rtl/rbm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
`include "round_brush_mask_alpha_top_macros.svh"
module rbm_cfg #(
  parameter int MAX_DIAMETER = rbm_pkg::MAX_DIAMETER_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rbm_pkg::rbm_cfg_t                   cfg_o
);

  localparam int DivW = 23;
  localparam int CntW = $clog2(DivW);
  localparam int HardProdW = 29;
  // ceil(2^26 / 25): hard * 65536 / 100 is exact as (hard * this) >> 12
  localparam logic [HardProdW-1:0] HardRecip = 29'd2684355;

  logic [rbm_pkg::SIZE_W-1:0]  size_q;
  logic [rbm_pkg::HARD_W-1:0]  hard_q;
  logic                        aa_q;
  logic [rbm_pkg::SIZE_W:0]    size_rnd;
  logic [rbm_pkg::HALF_W-1:0]  ceil_half;
  logic [rbm_pkg::HALF_W-1:0]  half;
  logic [rbm_pkg::WIDTH_W-1:0] width;
  logic [HardProdW-1:0]        hard_prod;

  logic                        busy_q;
  logic [CntW-1:0]             cnt_q;
  logic [rbm_pkg::WIDTH_W-1:0] remt_q, remt_d;
  logic [DivW-1:0]             qt_q;
  logic [DivW-1:0]             num_t;
  logic [rbm_pkg::WIDTH_W:0]   rt, rt_n;
  logic                        ge_t;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= rbm_pkg::SIZE_RST;
      hard_q <= rbm_pkg::HARD_RST;
      aa_q   <= rbm_pkg::AA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbm_pkg::CFG_BRUSH_SIZE: size_q <= cfg_data_i[rbm_pkg::SIZE_W-1:0];
        rbm_pkg::CFG_HARDNESS:   hard_q <= cfg_data_i[rbm_pkg::HARD_W-1:0];
        rbm_pkg::CFG_ANTIALIAS:  aa_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stamp half size, rounded up and limited
  always_comb begin
    size_rnd  = {1'b0, size_q} + (rbm_pkg::SIZE_W + 1)'(15);
    ceil_half = size_rnd[rbm_pkg::SIZE_W:4];
    half      = (int'(ceil_half) > MAX_DIAMETER) ? rbm_pkg::HALF_W'(MAX_DIAMETER) : ceil_half;
    width     = {half, 1'b1};
  end

  // hardness edge in Q16 by reciprocal multiply
  always_comb begin
    hard_prod = HardProdW'(hard_q) * HardRecip;
  end

  // one quotient bit a cycle for the band half width
  always_comb begin
    num_t  = DivW'(32768);
    rt     = {remt_q, num_t[cnt_q]};
    ge_t   = rt >= {1'b0, width};
    rt_n   = ge_t ? rt - {1'b0, width} : rt;
    remt_d = rt_n[rbm_pkg::WIDTH_W-1:0];
  end

  // restart on every write and after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivW - 1);
      remt_q <= '0;
      qt_q   <= '0;
    end else if (cfg_we_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivW - 1);
      remt_q <= '0;
      qt_q   <= '0;
    end else if (busy_q) begin
      remt_q <= remt_d;
      qt_q   <= {qt_q[DivW-2:0], ge_t};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_comb begin
    cfg_o.brush_size = size_q;
    cfg_o.half       = half;
    cfg_o.width      = width;
    cfg_o.hard_full  = hard_q >= rbm_pkg::HARD_FULL;
    cfg_o.hard_q16   = hard_prod[HardProdW-1:12];
    cfg_o.band_t     = aa_q ? qt_q[rbm_pkg::T_W-1:0] : '0;
    cfg_o.busy       = busy_q;
  end

  `RBM_ASSERT_NEXT(a_cfg_restart, clk_i, rst_ni, cfg_we_i, busy_q, "config not restarted")
  `RBM_ASSERT_NEXT(a_cfg_finish, clk_i, rst_ni, busy_q && cnt_q == '0 && !cfg_we_i, !busy_q, "overran")

endmodule
`default_nettype wire

// File: rtl/rbm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rbm_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rbm_pkg::rbm_cfg_t cfg_i,
  rbm_pix_if.sink           pix_in,
  output logic              item_valid_o,
  input  wire logic         item_ready_i,
  output rbm_pkg::rbm_item_t item_o
);

  logic                        fv_q;
  rbm_pkg::rbm_item_t          item_q, item_d;
  logic [rbm_pkg::COORD_W-1:0] half_ext, dx, dy;
  logic [rbm_pkg::DIST_W-1:0]  dxn, dyn;
  logic                        accept;

  assign pix_in.ready = !fv_q || item_ready_i;
  assign accept       = pix_in.valid && pix_in.ready;

  // classify the pixel and form its squared distance
  always_comb begin
    half_ext = rbm_pkg::COORD_W'(cfg_i.half);
    dx = (pix_in.pixel_x >= half_ext) ? pix_in.pixel_x - half_ext : half_ext - pix_in.pixel_x;
    dy = (pix_in.pixel_y >= half_ext) ? pix_in.pixel_y - half_ext : half_ext - pix_in.pixel_y;
    dxn = dx[rbm_pkg::DIST_W-1:0];
    dyn = dy[rbm_pkg::DIST_W-1:0];
    item_d.in_stamp = (cfg_i.brush_size != '0) && (pix_in.pixel_x < cfg_i.width)
                      && (pix_in.pixel_y < cfg_i.width);
    item_d.width  = cfg_i.width;
    item_d.d2     = rbm_pkg::D2_W'(dxn * dxn) + rbm_pkg::D2_W'(dyn * dyn);
  end

  // hold the beat until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (item_ready_i) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = fv_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// File: rtl/rbm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "round_brush_mask_alpha_top_macros.svh"
module rbm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire rbm_pkg::rbm_item_t push_data_i,
  input  wire logic          pop_i,
  output logic               pop_valid_o,
  output rbm_pkg::rbm_item_t pop_data_o
);

  localparam int Depth = rbm_pkg::FIFO_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  rbm_pkg::rbm_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  // advance pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `RBM_ASSERT(a_fifo_pop, clk_i, rst_ni, !(pop_i && cnt_q == '0), "pop from empty queue")
  `RBM_ASSERT_NEXT(a_fifo_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + CntW'(1), "level")

endmodule
`default_nettype wire

// File: rtl/rbm_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module rbm_div_pipe #(
  parameter int NUM_W  = 30,
  parameter int DEN_W  = 12,
  parameter int Q_W    = 18,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  // numerator must stay below den << Q_W
  localparam int ExtW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]    v_q;
  logic [NUM_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  logic [Q_W-1:0]    v_in;
  logic [NUM_W-1:0]  rem_in  [Q_W];
  logic [Q_W-1:0]    quo_in  [Q_W];
  logic [DEN_W-1:0]  den_in  [Q_W];
  logic [SIDE_W-1:0] side_in [Q_W];
  logic [NUM_W-1:0]  rem_nx  [Q_W];
  logic [Q_W-1:0]    quo_nx  [Q_W];
  logic [ExtW-1:0]   shd     [Q_W];
  logic [ExtW-1:0]   rem_ext [Q_W];
  logic [Q_W-1:0]    ge;

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      if (j == 0) begin
        v_in[j]    = valid_i;
        rem_in[j]  = num_i;
        quo_in[j]  = '0;
        den_in[j]  = den_i;
        side_in[j] = side_i;
      end else begin
        v_in[j]    = v_q[j-1];
        rem_in[j]  = rem_q[j-1];
        quo_in[j]  = quo_q[j-1];
        den_in[j]  = den_q[j-1];
        side_in[j] = side_q[j-1];
      end
      shd[j]     = ExtW'(den_in[j]) << (Q_W - 1 - j);
      rem_ext[j] = ExtW'(rem_in[j]);
      ge[j]      = rem_ext[j] >= shd[j];
      rem_nx[j]  = ge[j] ? NUM_W'(rem_ext[j] - shd[j]) : rem_in[j];
      quo_nx[j]  = quo_in[j] | (Q_W'(ge[j]) << (Q_W - 1 - j));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < Q_W; j++) begin
        rem_q[j]  <= rem_nx[j];
        quo_q[j]  <= quo_nx[j];
        den_q[j]  <= den_in[j];
        side_q[j] <= side_in[j];
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule
`default_nettype wire

// File: rtl/rbm_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "round_brush_mask_alpha_top_macros.svh"
module rbm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rbm_pkg::rbm_cfg_t  cfg_i,
  input  wire logic          item_valid_i,
  input  wire rbm_pkg::rbm_item_t item_i,
  output logic               item_pop_o,
  rbm_alpha_if.source        alpha_out
);

  localparam int RootW = rbm_pkg::ROOT_W;
  localparam int RemW  = RootW + 2;
  localparam int NW    = 2 * RootW;
  localparam int RW    = rbm_pkg::RATIO_W;
  localparam int QW    = rbm_pkg::Q16_W;
  localparam int WW    = rbm_pkg::WIDTH_W;
  localparam int CNumW = QW + 16;
  localparam int FNumW = 2 * QW;

  typedef struct packed {
    logic          in_stamp;
    logic [WW-1:0] width;
    logic          sat;
  } ratio_side_t;

  typedef struct packed {
    logic          zero;
    logic [WW-1:0] width;
    logic [RW-1:0] r;
    logic          a_full;
    logic          a_zero;
  } core_side_t;

  typedef struct packed {
    logic          zero;
    logic [WW-1:0] width;
    logic          feather;
    logic [QW-1:0] a;
  } edge_side_t;

  logic en;

  // ---------------- square root, two radicand bits per stage
  logic [RootW-1:0]   sq_v_q;
  logic [RootW-1:0]   sq_root_q [RootW];
  logic [RemW-1:0]    sq_rem_q  [RootW];
  rbm_pkg::rbm_item_t sq_item_q [RootW];

  logic [RootW-1:0]   sq_v_in;
  logic [RootW-1:0]   sq_root_in [RootW];
  logic [RemW-1:0]    sq_rem_in  [RootW];
  rbm_pkg::rbm_item_t sq_item_in [RootW];
  logic [NW-1:0]      sq_n       [RootW];
  logic [RemW-1:0]    sq_sh      [RootW];
  logic [RemW-1:0]    sq_trial   [RootW];
  logic [RootW-1:0]   sq_ge;

  assign en         = !alpha_out.valid || alpha_out.ready;
  assign item_pop_o = en && item_valid_i;

  always_comb begin
    for (int i = 0; i < RootW; i++) begin
      if (i == 0) begin
        sq_v_in[i]    = item_valid_i;
        sq_root_in[i] = '0;
        sq_rem_in[i]  = '0;
        sq_item_in[i] = item_i;
      end else begin
        sq_v_in[i]    = sq_v_q[i-1];
        sq_root_in[i] = sq_root_q[i-1];
        sq_rem_in[i]  = sq_rem_q[i-1];
        sq_item_in[i] = sq_item_q[i-1];
      end
      sq_n[i]     = {sq_item_in[i].d2, {(NW - rbm_pkg::D2_W){1'b0}}};
      sq_sh[i]    = {sq_rem_in[i][RemW-3:0], sq_n[i][2*(RootW-1-i) +: 2]};
      sq_trial[i] = {sq_root_in[i], 2'b01};
      sq_ge[i]    = sq_sh[i] >= sq_trial[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
    end else if (en) begin
      sq_v_q <= sq_v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < RootW; i++) begin
        sq_root_q[i] <= {sq_root_in[i][RootW-2:0], sq_ge[i]};
        sq_rem_q[i]  <= sq_ge[i] ? sq_sh[i] - sq_trial[i] : sq_sh[i];
        sq_item_q[i] <= sq_item_in[i];
      end
    end
  end

  // ---------------- saturation check ahead of the ratio divide
  logic             st_v_q;
  logic [RootW-1:0] st_num_q;
  ratio_side_t      st_side_q, st_side_d;
  logic [RootW-1:0] sq_out;

  always_comb begin
    sq_out             = sq_root_q[RootW-1];
    st_side_d.in_stamp = sq_item_q[RootW-1].in_stamp;
    st_side_d.width    = sq_item_q[RootW-1].width;
    st_side_d.sat      = sq_out >= {cfg_i.brush_size, {RW{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else if (en) begin
      st_v_q <= sq_v_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_side_q <= st_side_d;
      st_num_q  <= st_side_d.sat ? '0 : sq_out;
    end
  end

  logic          d1_v;
  logic [RW-1:0] d1_q;
  ratio_side_t   d1_side;

  rbm_div_pipe #(
    .NUM_W (RootW),
    .DEN_W (rbm_pkg::SIZE_W),
    .Q_W   (RW),
    .SIDE_W($bits(ratio_side_t))
  ) u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(st_v_q),
    .num_i  (st_num_q),
    .den_i  (cfg_i.brush_size),
    .side_i (st_side_q),
    .valid_o(d1_v),
    .quo_o  (d1_q),
    .side_o (d1_side)
  );

  // ---------------- classify against the core and the edge band
  logic          c_v_q;
  core_side_t    c_side_q, c_side_d;
  logic [CNumW-1:0] c_num_q, c_num_d;
  logic [QW-1:0] c_den_q;
  logic [RW-1:0] r_val, high;
  logic [QW-1:0] diff;

  always_comb begin
    r_val           = d1_side.sat ? '1 : d1_q;
    high            = RW'(rbm_pkg::ONE_Q16) + RW'(cfg_i.band_t);
    c_side_d.zero   = !d1_side.in_stamp || (r_val >= high);
    c_side_d.width  = d1_side.width;
    c_side_d.r      = r_val;
    c_side_d.a_full = cfg_i.hard_full || (r_val <= RW'(cfg_i.hard_q16));
    c_side_d.a_zero = r_val >= RW'(rbm_pkg::ONE_Q16);
    diff            = rbm_pkg::ONE_Q16 - r_val[QW-1:0];
    c_num_d = (c_side_d.a_full || c_side_d.a_zero) ? '0 : {diff, 16'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q <= c_side_d;
      c_num_q  <= c_num_d;
      c_den_q  <= rbm_pkg::ONE_Q16 - cfg_i.hard_q16;
    end
  end

  logic          d2_v;
  logic [QW-1:0] d2_q;
  core_side_t    d2_side;

  rbm_div_pipe #(
    .NUM_W (CNumW),
    .DEN_W (QW),
    .Q_W   (QW),
    .SIDE_W($bits(core_side_t))
  ) u_div_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(c_v_q),
    .num_i  (c_num_q),
    .den_i  (c_den_q),
    .side_i (c_side_q),
    .valid_o(d2_v),
    .quo_o  (d2_q),
    .side_o (d2_side)
  );

  // ---------------- weight the core alpha by the feather ramp
  logic             m_v_q;
  edge_side_t       m_side_q, m_side_d;
  logic [FNumW-1:0] m_num_q, m_num_d;
  logic [QW-1:0]    m_den_q;
  logic [QW-1:0]    low;
  logic [RW-1:0]    high2, span;

  always_comb begin
    high2          = RW'(rbm_pkg::ONE_Q16) + RW'(cfg_i.band_t);
    low            = rbm_pkg::ONE_Q16 - QW'(cfg_i.band_t);
    m_side_d.zero  = d2_side.zero;
    m_side_d.width = d2_side.width;
    m_side_d.a     = d2_side.a_full ? rbm_pkg::ONE_Q16 : (d2_side.a_zero ? '0 : d2_q);
    m_side_d.feather = (cfg_i.band_t != '0) && (d2_side.r > RW'(low));
    span           = high2 - d2_side.r;
    m_num_d = (d2_side.zero || !m_side_d.feather) ? '0 : m_side_d.a * span[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q <= m_side_d;
      m_num_q  <= m_num_d;
      m_den_q  <= {cfg_i.band_t, 1'b0};
    end
  end

  logic          d3_v;
  logic [QW-1:0] d3_q;
  edge_side_t    d3_side;

  rbm_div_pipe #(
    .NUM_W (FNumW),
    .DEN_W (QW),
    .Q_W   (QW),
    .SIDE_W($bits(edge_side_t))
  ) u_div_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(m_v_q),
    .num_i  (m_num_q),
    .den_i  (m_den_q),
    .side_i (m_side_q),
    .valid_o(d3_v),
    .quo_o  (d3_q),
    .side_o (d3_side)
  );

  // ---------------- scale to eight bits and hold the result beat
  logic                        out_v_q;
  logic [rbm_pkg::ALPHA_W-1:0] alpha_q, alpha_d;
  logic [WW-1:0]               width_q;
  logic [QW-1:0]               f;
  logic [25:0]                 scaled;

  always_comb begin
    f = d3_side.zero ? '0 : (d3_side.feather ? d3_q : d3_side.a);
    scaled = (26'(f) << 8) - 26'(f) + 26'd32768;
    alpha_d = (scaled[25:16] > 10'd255) ? 8'd255 : scaled[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q <= alpha_d;
      width_q <= d3_side.width;
    end
  end

  assign alpha_out.valid       = out_v_q;
  assign alpha_out.mask_alpha  = alpha_q;
  assign alpha_out.stamp_width = width_q;

  `RBM_ASSERT(a_cfg_settled, clk_i, rst_ni, !(d1_v && cfg_i.busy), "config not settled")
  `RBM_ASSERT(a_zero_alpha, clk_i, rst_ni, !(d3_v && d3_side.zero && alpha_d != '0), "alpha off stamp")

endmodule
`default_nettype wire

// File: rtl/round_brush_mask_alpha_top.sv
// Round brush mask: takes one pixel coordinate per beat and returns its alpha
// (0..255) together with the stamp side length. A new pixel is taken every
// clock cycle while the result side keeps up. After it is accepted, a pixel
// passes through the input register, the queue, the 30-stage square root, a
// saturation stage, the three pipelined dividers of 18, 17 and 17 stages
// with a classify stage ahead of the second and third, and the output
// register. A short queue parts the input stage from the arithmetic
// pipeline, and a stall at the output freezes the whole arithmetic
// pipeline. After reset, and after every register write, the feather band
// constant is rebuilt by a serial divider while the hardness edge follows
// its register at once; this needs no wait, as the rebuild ends before a
// pixel accepted after the write reaches the first stage that uses the band.
`timescale 1ns / 1ps
`default_nettype none
module round_brush_mask_alpha_top #(
  parameter int MAX_DIAMETER = rbm_pkg::MAX_DIAMETER_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rbm_pix_if.sink                             pix_in,
  rbm_alpha_if.source                         alpha_out
);

  rbm_pkg::rbm_cfg_t  cfg;
  rbm_pkg::rbm_item_t fr_item, q_item;
  logic               fr_valid, q_ready, q_valid, q_pop;

  rbm_cfg #(
    .MAX_DIAMETER(MAX_DIAMETER)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  rbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pix_in      (pix_in),
    .item_valid_o(fr_valid),
    .item_ready_i(q_ready),
    .item_o      (fr_item)
  );

  rbm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(q_ready),
    .push_data_i (fr_item),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_item)
  );

  rbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_valid_i(q_valid),
    .item_i      (q_item),
    .item_pop_o  (q_pop),
    .alpha_out   (alpha_out)
  );

endmodule
`default_nettype wire

// File: test/tb_round_brush_mask_alpha_top.sv
`timescale 1ns / 1ps
module tb_round_brush_mask_alpha_top;
  import rbm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [WIDTH_W-1:0] width;
  } coverage_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rbm_pix_if pix ();
  rbm_alpha_if alpha ();

  round_brush_mask_alpha_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix),
    .alpha_out  (alpha)
  );

  // shadow copy of the brush registers
  logic [SIZE_W-1:0] brush_size_q;
  logic [HARD_W-1:0] hardness_q;
  logic              antialias_q;

  coord_t    pixel_pending_q[$];
  coverage_t coverage_expected_q[$];
  int        failures;
  int        cycle_count;
  int        beats_in;
  int        beats_out;
  int        configs_run;
  bit        pix_taken;
  bit        stall_armed;
  bit        stall_done;
  int        stall_left;

  // largest q below 2^18 with (q*size)^2 <= d2 * 2^42
  function automatic logic [RATIO_W-1:0] edge_ratio(longint unsigned d2,
                                                    longint unsigned size);
    longint unsigned bound;
    longint unsigned prod;
    logic [RATIO_W-1:0] q;
    bound = d2 << 42;
    q = '0;
    for (int b = RATIO_W - 1; b >= 0; b--) begin
      prod = longint'(q | (18'd1 << b)) * size;
      if (prod * prod <= bound) q = q | (18'd1 << b);
    end
    return q;
  endfunction

  // coverage of one pixel under the current brush
  function automatic coverage_t brush_coverage(coord_t c);
    coverage_t res;
    longint unsigned half, w, dx, dy, r, t, lo, hi, h, a, f;
    half = (longint'(brush_size_q) + 15) >> 4;
    if (half > MAX_DIAMETER_DEF) half = MAX_DIAMETER_DEF;
    w = 1 + 2 * half;
    res.width = w[WIDTH_W-1:0];
    res.alpha = '0;
    if (brush_size_q != 0 && c.x < w && c.y < w) begin
      dx = (c.x >= half) ? c.x - half : half - c.x;
      dy = (c.y >= half) ? c.y - half : half - c.y;
      r = edge_ratio(dx * dx + dy * dy, brush_size_q);
      t = antialias_q ? (32768 / w) : 0;
      lo = 65536 - t;
      hi = 65536 + t;
      if (r < hi) begin
        if (hardness_q >= HARD_FULL) begin
          a = 65536;
        end else begin
          h = (longint'(hardness_q) * 65536) / 100;
          if (r <= h) a = 65536;
          else if (r < 65536) a = ((65536 - r) * 65536) / (65536 - h);
          else a = 0;
        end
        if (r <= lo || t == 0) f = a;
        else f = (a * (hi - r)) / (2 * t);
        f = (f * 255 + 32768) >> 16;
        res.alpha = (f > 255) ? 8'd255 : f[7:0];
      end
    end
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // quiet window with no idling on either side
  function automatic bit calm_window();
    return cycle_count >= 1500 && cycle_count < 2500;
  endfunction

  // count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // record accepted pixels and predict their coverage
  always @(posedge clk_i) begin
    pix_taken <= rst_ni && pix.valid && pix.ready;
    if (rst_ni && pix.valid && pix.ready) begin
      coverage_expected_q.push_back(brush_coverage(pixel_pending_q.pop_front()));
      beats_in <= beats_in + 1;
    end
  end

  // offer pending pixels, idling at random
  always @(negedge clk_i) begin
    if (rst_ni && (!pix.valid || pix_taken)) begin
      if (pixel_pending_q.size() != 0 &&
          (calm_window() || $urandom_range(99) >= 18)) begin
        pix.valid   <= 1'b1;
        pix.pixel_x <= pixel_pending_q[0].x;
        pix.pixel_y <= pixel_pending_q[0].y;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // result side readiness, with one long hold-off
  always @(negedge clk_i) begin
    int left;
    left = stall_left;
    if (left > 0) left = left - 1;
    else if (stall_armed && !stall_done) begin
      left = 300;
      stall_done <= 1'b1;
    end
    stall_left <= left;
    alpha.ready <= rst_ni && left == 0 && (calm_window() || $urandom_range(99) >= 18);
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    coverage_t exp_c;
    if (rst_ni && alpha.valid && alpha.ready) begin
      beats_out <= beats_out + 1;
      if (coverage_expected_q.size() == 0) begin
        $error("result beat with no pixel outstanding");
        failures++;
      end else begin
        exp_c = coverage_expected_q.pop_front();
        if (alpha.mask_alpha !== exp_c.alpha) begin
          $error("mask_alpha: expected %0d, got %0d", exp_c.alpha, alpha.mask_alpha);
          failures++;
        end
        if (alpha.stamp_width !== exp_c.width) begin
          $error("stamp_width: expected %0d, got %0d", exp_c.width, alpha.stamp_width);
          failures++;
        end
      end
    end
  end

  // write one brush register and update the shadow copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_BRUSH_SIZE: brush_size_q = value[SIZE_W-1:0];
      CFG_HARDNESS:   hardness_q   = value[HARD_W-1:0];
      CFG_ANTIALIAS:  antialias_q  = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_brush(int size, int hard, int aa);
    write_reg(CFG_BRUSH_SIZE, size);
    write_reg(CFG_HARDNESS, hard);
    write_reg(CFG_ANTIALIAS, aa);
    configs_run++;
  endtask

  task automatic queue_pixel(int x, int y);
    coord_t c;
    c.x = x[COORD_W-1:0];
    c.y = y[COORD_W-1:0];
    pixel_pending_q.push_back(c);
  endtask

  // hold until every pixel is in and every result is out
  task automatic drain();
    while (pixel_pending_q.size() != 0 || coverage_expected_q.size() != 0)
      @(posedge clk_i);
  endtask

  // stamp edges and centre, then random pixels mostly inside the stamp
  task automatic stamp_pixels(int n);
    int half, w, lim;
    half = (brush_size_q + 15) >> 4;
    if (half > MAX_DIAMETER_DEF) half = MAX_DIAMETER_DEF;
    w = 1 + 2 * half;
    lim = (w + 1 > 512) ? 512 : w + 1;
    queue_pixel(half, half);
    queue_pixel(0, half);
    queue_pixel(w - 1, half);
    queue_pixel(half, w);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) queue_pixel($urandom_range(lim), $urandom_range(lim));
      else queue_pixel($urandom_range(512), $urandom_range(512));
    end
  endtask

  initial begin
    int sizes[12];
    int hards[12];
    failures = 0;
    cycle_count = 0;
    beats_in = 0;
    beats_out = 0;
    configs_run = 0;
    stall_armed = 0;
    stall_done = 0;
    stall_left = 0;
    pix_taken = 0;
    brush_size_q = SIZE_RST;
    hardness_q   = HARD_RST;
    antialias_q  = AA_RST;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BRUSH_SIZE;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    alpha.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pixels under the reset brush (size 320, half size 20, stamp 41)
    queue_pixel(0, 0);
    queue_pixel(20, 20);
    queue_pixel(40, 40);
    queue_pixel(40, 20);
    queue_pixel(20, 0);
    queue_pixel(41, 20);
    queue_pixel(20, 41);
    queue_pixel(512, 512);
    queue_pixel(511, 0);
    queue_pixel(0, 511);
    queue_pixel(1023, 20);
    queue_pixel(20, 1023);
    queue_pixel(6, 6);
    queue_pixel(34, 34);
    drain();

    // zero size, hardness above range, widest stamp
    set_brush(0, 50, 1);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(512, 512);
    drain();
    set_brush(4095, 127, 0);
    queue_pixel(256, 256);
    queue_pixel(0, 0);
    queue_pixel(512, 512);
    queue_pixel(512, 256);
    queue_pixel(0, 256);
    queue_pixel(1023, 1023);
    drain();

    sizes = '{1, 15, 16, 17, 100, 320, 777, 4095, 4080, 63, 2048, 255};
    hards = '{0, 100, 50, 127, 1, 99, 0, 30, 100, 75, 0, 64};
    for (int p = 0; p < 12; p++) begin
      set_brush(sizes[p], hards[p], p % 2);
      if (p == 4) stall_armed = 1;
      stamp_pixels(p == 4 ? 120 : 50);
      drain();
    end
    // random brushes
    for (int p = 0; p < 3; p++) begin
      set_brush($urandom_range(4095), $urandom_range(127), $urandom_range(1));
      stamp_pixels(40);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d pixels in, %0d results out, over %0d brush settings",
             beats_in, beats_out, configs_run);
    $display("settings reached zero size, widest stamp, hardness 0..127, both edge modes");
    if (failures == 0 && coverage_expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: round_brush_mask_alpha_top.f
+incdir+rtl
rtl/rbm_pkg.sv
rtl/rbm_if.sv
rtl/rbm_cfg.sv
rtl/rbm_front.sv
rtl/rbm_fifo.sv
rtl/rbm_div_pipe.sv
rtl/rbm_back.sv
rtl/round_brush_mask_alpha_top.sv
test/tb_round_brush_mask_alpha_top.sv
